// ===== sv/glewq_pkg.sv =====
// ----------------------------------------------------------------------------
// glewq_pkg
// Shared types and constants for the grid wire-length table.
// ----------------------------------------------------------------------------
package glewq_pkg;

    localparam int CoordInBits = 32;
    localparam int IdxBits     = 10;
    localparam int WlBits      = 40;

    typedef enum logic [1:0] {
        CMD_LOAD_X = 2'd0,
        CMD_LOAD_Y = 2'd1,
        CMD_BUILD  = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_BUILT = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        AX_OP_LOAD  = 2'd0,
        AX_OP_BUILD = 2'd1,
        AX_OP_QUERY = 2'd2
    } t_ax_op;

    typedef enum logic [3:0] {
        AX_IDLE,
        AX_SCAN_RD,
        AX_SCAN_CMP,
        AX_PLACE,
        AX_SHIFT_RD,
        AX_SHIFT_WR,
        AX_INS,
        AX_BLD_RD,
        AX_BLD_ACC,
        AX_Q_RD2,
        AX_Q_SUB,
        AX_DONE
    } t_ax_state;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN
    } t_top_state;

    typedef struct packed {
        logic                   start;
        t_ax_op                 op;
        logic [CoordInBits-1:0] coord;
        logic [IdxBits-1:0]     idx_a;
        logic [IdxBits-1:0]     idx_b;
    } t_ax_req;

    typedef struct packed {
        logic              done;
        logic              full;
        logic [WlBits-1:0] span;
    } t_ax_rsp;

endpackage

// ===== sv/glewq_ram.sv =====
// ----------------------------------------------------------------------------
// glewq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module glewq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/glewq_axis.sv =====
// ----------------------------------------------------------------------------
// glewq_axis
// One axis: sorted line list, prefix table and the sequencer that inserts,
// builds and looks up spans through one shared datapath.
// ----------------------------------------------------------------------------
module glewq_axis #(
    parameter int MAX_LINES  = 1024,
    parameter int COORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  glewq_pkg::t_ax_req                i_req,
    output glewq_pkg::t_ax_rsp                o_rsp,
    output logic [$clog2(MAX_LINES+1)-1:0]    o_entries
);
    import glewq_pkg::*;

    localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int AW   = $clog2(MAX_LINES);
    localparam int CNTW = $clog2(MAX_LINES + 1);
    localparam int IW   = (CNTW > IdxBits) ? CNTW : IdxBits;
    localparam logic [CNTW-1:0] MaxCnt = CNTW'(MAX_LINES);

    t_ax_state r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt, r_entries, n_entries;
    logic [CNTW-1:0]   r_i, n_i, r_k, n_k;
    logic signed [CW-1:0] r_coord, n_coord, r_prev, n_prev, r_mprev, n_mprev;
    logic [WlBits-1:0] r_acc, n_acc, r_lo, n_lo, r_span, n_span;
    logic [IW-1:0]     r_hi, n_hi;
    logic              r_full, n_full;

    logic              line_we, pre_we;
    logic [AW-1:0]     line_waddr, line_raddr, pre_waddr, pre_raddr;
    logic [CW-1:0]     line_wdata, line_rdata;
    logic [WlBits-1:0] pre_wdata, pre_rdata;

    logic signed [CW-1:0] rd_s, mid;
    logic signed [CW:0]   sum, sum_t, diff;
    logic [IW-1:0]        ia, ib;

    glewq_ram #(.DEPTH(MAX_LINES), .WIDTH(CW)) u_lines (
        .i_clk(i_clk), .i_we(line_we), .i_waddr(line_waddr), .i_wdata(line_wdata),
        .i_raddr(line_raddr), .o_rdata(line_rdata)
    );

    glewq_ram #(.DEPTH(MAX_LINES), .WIDTH(WlBits)) u_prefix (
        .i_clk(i_clk), .i_we(pre_we), .i_waddr(pre_waddr), .i_wdata(pre_wdata),
        .i_raddr(pre_raddr), .o_rdata(pre_rdata)
    );

    assign rd_s  = signed'(line_rdata);
    assign sum   = {r_prev[CW-1], r_prev} + {rd_s[CW-1], rd_s};
    assign sum_t = sum + {{CW{1'b0}}, sum[CW]};
    assign mid   = sum_t[CW:1];
    assign diff  = {mid[CW-1], mid} - {r_mprev[CW-1], r_mprev};
    assign ia    = IW'(i_req.idx_a);
    assign ib    = IW'(i_req.idx_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= AX_IDLE;
            r_cnt     <= '0;
            r_entries <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_entries <= n_entries;
        end
        r_i     <= n_i;
        r_k     <= n_k;
        r_coord <= n_coord;
        r_prev  <= n_prev;
        r_mprev <= n_mprev;
        r_acc   <= n_acc;
        r_lo    <= n_lo;
        r_span  <= n_span;
        r_hi    <= n_hi;
        r_full  <= n_full;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_entries = r_entries;
        n_i       = r_i;
        n_k       = r_k;
        n_coord   = r_coord;
        n_prev    = r_prev;
        n_mprev   = r_mprev;
        n_acc     = r_acc;
        n_lo      = r_lo;
        n_span    = r_span;
        n_hi      = r_hi;
        n_full    = r_full;
        line_we    = 1'b0;
        line_waddr = r_k[AW-1:0];
        line_wdata = line_rdata;
        line_raddr = r_i[AW-1:0];
        pre_we     = 1'b0;
        pre_waddr  = '0;
        pre_wdata  = '0;
        pre_raddr  = r_hi[AW-1:0];
        o_rsp      = '0;

        case (r_state)
            AX_IDLE: begin
                if (i_req.start) begin
                    n_full = 1'b0;
                    n_span = '0;
                    n_i    = '0;
                    case (i_req.op)
                        AX_OP_LOAD: begin
                            n_coord = signed'(i_req.coord[CW-1:0]);
                            n_state = AX_SCAN_RD;
                        end
                        AX_OP_BUILD: begin
                            pre_we    = 1'b1;
                            n_acc     = '0;
                            n_entries = (r_cnt >= CNTW'(2)) ? r_cnt - CNTW'(1) : CNTW'(1);
                            n_state   = (r_cnt >= CNTW'(3)) ? AX_BLD_RD : AX_DONE;
                        end
                        AX_OP_QUERY: begin
                            pre_raddr = (ia < ib) ? ia[AW-1:0] : ib[AW-1:0];
                            n_hi      = (ia < ib) ? ib : ia;
                            n_state   = AX_Q_RD2;
                        end
                        default: n_state = AX_DONE;
                    endcase
                end
            end
            AX_SCAN_RD: begin
                n_state = (r_i == r_cnt) ? AX_PLACE : AX_SCAN_CMP;
            end
            AX_SCAN_CMP: begin
                if (rd_s < r_coord) begin
                    n_i     = r_i + CNTW'(1);
                    n_state = AX_SCAN_RD;
                end else if (rd_s == r_coord) begin
                    n_state = AX_DONE;
                end else begin
                    n_state = AX_PLACE;
                end
            end
            AX_PLACE: begin
                if (r_cnt == MaxCnt) begin
                    n_full  = 1'b1;
                    n_state = AX_DONE;
                end else begin
                    n_k     = r_cnt;
                    n_state = AX_SHIFT_RD;
                end
            end
            AX_SHIFT_RD: begin
                line_raddr = AW'(r_k - CNTW'(1));
                n_state    = (r_k == r_i) ? AX_INS : AX_SHIFT_WR;
            end
            AX_SHIFT_WR: begin
                line_we = 1'b1;
                n_k     = r_k - CNTW'(1);
                n_state = AX_SHIFT_RD;
            end
            AX_INS: begin
                line_we    = 1'b1;
                line_waddr = r_i[AW-1:0];
                line_wdata = r_coord;
                n_cnt      = r_cnt + CNTW'(1);
                n_state    = AX_DONE;
            end
            AX_BLD_RD: begin
                n_state = AX_BLD_ACC;
            end
            AX_BLD_ACC: begin
                n_prev = rd_s;
                if (r_i != '0) begin
                    n_mprev = mid;
                end
                if (r_i >= CNTW'(2)) begin
                    n_acc     = r_acc + {{(WlBits-CW-1){diff[CW]}}, diff};
                    pre_we    = 1'b1;
                    pre_waddr = AW'(r_i - CNTW'(1));
                    pre_wdata = n_acc;
                end
                if (r_i == r_cnt - CNTW'(1)) begin
                    n_state = AX_DONE;
                end else begin
                    n_i     = r_i + CNTW'(1);
                    n_state = AX_BLD_RD;
                end
            end
            AX_Q_RD2: begin
                n_lo    = pre_rdata;
                n_state = AX_Q_SUB;
            end
            AX_Q_SUB: begin
                n_span  = pre_rdata - r_lo;
                n_state = AX_DONE;
            end
            AX_DONE: begin
                o_rsp.done = 1'b1;
                o_rsp.full = r_full;
                o_rsp.span = r_span;
                n_state    = AX_IDLE;
            end
            default: n_state = AX_IDLE;
        endcase
    end

    assign o_entries = r_entries;
endmodule

// ===== sv/grid_edge_length_wire_query.sv =====
// ----------------------------------------------------------------------------
// grid_edge_length_wire_query
// Routing-grid line lists, per-axis prefix tables and wire-length queries.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its single result
// appears on o_wire_length / o_status for one cycle with o_valid high; the
// receiver has no way to stall it.
// Load x/y: linear scan of the sorted list (read and compare states per entry
// passed) plus a shift of the entries above the insert point (read and write
// states each), through the axis line RAM port. A duplicate ends at the scan.
// Build: both axes walk their lists in parallel, read and accumulate states
// per line; the longer list sets the time.
// Query: from transfer to result there are two prefix RAM reads per axis,
// one subtract, and the final sum into the result register. The next command
// is taken at the edge that ends the result cycle; queries do not overlap.
// A query before a build or with an index out of range answers in
// the cycle after the transfer and the next command can follow at once.
// Reset clears counts and the built flag; RAM contents stay undefined and
// are never used before being written.
// ----------------------------------------------------------------------------
module grid_edge_length_wire_query #(
    parameter int MAX_LINES  = 1024,
    parameter int COORD_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_command,
    input  logic signed [glewq_pkg::CoordInBits-1:0] i_coord,
    input  logic [glewq_pkg::IdxBits-1:0]         i_p_col,
    input  logic [glewq_pkg::IdxBits-1:0]         i_p_row,
    input  logic [glewq_pkg::IdxBits-1:0]         i_q_col,
    input  logic [glewq_pkg::IdxBits-1:0]         i_q_row,
    output logic                                  o_valid,
    output logic [glewq_pkg::WlBits-1:0]          o_wire_length,
    output logic [1:0]                            o_status
);
    import glewq_pkg::*;

    localparam int CNTW = $clog2(MAX_LINES + 1);
    localparam int IW   = (CNTW > IdxBits) ? CNTW : IdxBits;

    t_top_state r_state, n_state;
    t_cmd    r_cmd, n_cmd, cmd_in;
    logic    r_built, n_built, r_wx, n_wx, r_wy, n_wy;
    logic    r_valid, n_valid, r_fullf, n_fullf;
    logic [WlBits-1:0] r_wl, n_wl, r_sx, n_sx, r_sy, n_sy;
    t_status r_status, n_status;

    t_ax_req req_x, req_y;
    t_ax_rsp rsp_x, rsp_y;
    logic [CNTW-1:0] ent_x, ent_y;
    logic range_bad;

    glewq_axis #(.MAX_LINES(MAX_LINES), .COORD_BITS(COORD_BITS)) u_axis_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_x), .o_rsp(rsp_x), .o_entries(ent_x)
    );
    glewq_axis #(.MAX_LINES(MAX_LINES), .COORD_BITS(COORD_BITS)) u_axis_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_y), .o_rsp(rsp_y), .o_entries(ent_y)
    );

    assign cmd_in    = t_cmd'(i_command);
    assign range_bad = (IW'(i_p_col) >= IW'(ent_x)) || (IW'(i_q_col) >= IW'(ent_x)) ||
                       (IW'(i_p_row) >= IW'(ent_y)) || (IW'(i_q_row) >= IW'(ent_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_built <= 1'b0;
            r_valid <= 1'b0;
            r_wx    <= 1'b0;
            r_wy    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_built <= n_built;
            r_valid <= n_valid;
            r_wx    <= n_wx;
            r_wy    <= n_wy;
        end
        r_cmd    <= n_cmd;
        r_wl     <= n_wl;
        r_status <= n_status;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_fullf  <= n_fullf;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_built  = r_built;
        n_valid  = 1'b0;
        n_wx     = r_wx;
        n_wy     = r_wy;
        n_wl     = r_wl;
        n_status = r_status;
        n_sx     = rsp_x.done ? rsp_x.span : r_sx;
        n_sy     = rsp_y.done ? rsp_y.span : r_sy;
        n_fullf  = r_fullf | rsp_x.full | rsp_y.full;
        req_x       = '0;
        req_y       = '0;
        req_x.coord = i_coord;
        req_y.coord = i_coord;
        req_x.idx_a = i_p_col;
        req_x.idx_b = i_q_col;
        req_y.idx_a = i_p_row;
        req_y.idx_b = i_q_row;

        case (r_state)
            T_IDLE: begin
                if (start) begin
                    n_cmd   = cmd_in;
                    n_fullf = 1'b0;
                    case (cmd_in)
                        CMD_LOAD_X: begin
                            n_built     = 1'b0;
                            req_x.start = 1'b1;
                            req_x.op    = AX_OP_LOAD;
                            n_wx        = 1'b1;
                            n_state     = T_RUN;
                        end
                        CMD_LOAD_Y: begin
                            n_built     = 1'b0;
                            req_y.start = 1'b1;
                            req_y.op    = AX_OP_LOAD;
                            n_wy        = 1'b1;
                            n_state     = T_RUN;
                        end
                        CMD_BUILD: begin
                            n_built     = 1'b1;
                            req_x.start = 1'b1;
                            req_y.start = 1'b1;
                            req_x.op    = AX_OP_BUILD;
                            req_y.op    = AX_OP_BUILD;
                            n_wx        = 1'b1;
                            n_wy        = 1'b1;
                            n_state     = T_RUN;
                        end
                        default: begin
                            if (!r_built) begin
                                n_valid  = 1'b1;
                                n_wl     = '0;
                                n_status = ST_NOT_BUILT;
                            end else if (range_bad) begin
                                n_valid  = 1'b1;
                                n_wl     = '0;
                                n_status = ST_RANGE;
                            end else begin
                                req_x.start = 1'b1;
                                req_y.start = 1'b1;
                                req_x.op    = AX_OP_QUERY;
                                req_y.op    = AX_OP_QUERY;
                                n_wx        = 1'b1;
                                n_wy        = 1'b1;
                                n_state     = T_RUN;
                            end
                        end
                    endcase
                end
            end
            T_RUN: begin
                n_wx = r_wx & ~rsp_x.done;
                n_wy = r_wy & ~rsp_y.done;
                if (!n_wx && !n_wy) begin
                    n_valid  = 1'b1;
                    n_state  = T_IDLE;
                    n_wl     = (r_cmd == CMD_QUERY) ? n_sx + n_sy : '0;
                    n_status = n_fullf ? ST_FULL : ST_OK;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    assign busy          = (r_state != T_IDLE);
    assign o_valid       = r_valid;
    assign o_wire_length = r_wl;
    assign o_status      = r_status;

    a_fall_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_wire_length == '0))
        else $error("failed command returned nonzero length");

    a_transfer_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("transfer neither started work nor answered");

    a_full_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_cmd == CMD_LOAD_X || r_cmd == CMD_LOAD_Y))
        else $error("list full reported for a non-load command");
endmodule

// ===== tb/tb_grid_edge_length_wire_query.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_edge_length_wire_query
// Self-checking bench for the routing-grid wire-length table. A stimulus
// table, random command mixes, and a final x-list fill up to capacity are
// driven through the start/busy handshake. Results are scored against an
// in-bench model of the line lists and prefix tables or typed row values.
// ----------------------------------------------------------------------------
module tb_grid_edge_length_wire_query;
    import glewq_pkg::*;

    localparam int MaxLines = 1024;
    localparam logic [WlBits-1:0] WlZero = '0;

    typedef struct {
        t_cmd              cmd;
        logic signed [31:0] coord;
        logic [9:0]        pc, pr, qc, qr;
        bit                typed;
        logic [WlBits-1:0] wl;
        t_status           st;
    } t_row;

    typedef struct {
        logic [WlBits-1:0] wl;
        t_status           st;
    } t_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_command = '0;
    logic signed [31:0] i_coord = '0;
    logic [9:0]        i_p_col = '0, i_p_row = '0, i_q_col = '0, i_q_row = '0;
    logic              o_valid;
    logic [WlBits-1:0] o_wire_length;
    logic [1:0]        o_status;

    grid_edge_length_wire_query dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_coord(i_coord),
        .i_p_col(i_p_col), .i_p_row(i_p_row), .i_q_col(i_q_col), .i_q_row(i_q_row),
        .o_valid(o_valid), .o_wire_length(o_wire_length), .o_status(o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // table model
    longint            lines_x[MaxLines], lines_y[MaxLines];
    int                cnt_x = 0, cnt_y = 0, ent_x = 0, ent_y = 0;
    logic [WlBits-1:0] pre_x[MaxLines], pre_y[MaxLines];
    bit                built = 0;

    t_answer answers_pending[$];
    int      mismatches = 0;

    function automatic t_status insert_coord(ref longint lines[MaxLines], ref int cnt,
                                             input longint c);
        int pos;
        pos = 0;
        while (pos < cnt && lines[pos] < c) pos++;
        if (pos < cnt && lines[pos] == c) return ST_OK;
        if (cnt >= MaxLines) return ST_FULL;
        for (int i = cnt; i > pos; i--) lines[i] = lines[i-1];
        lines[pos] = c;
        cnt++;
        return ST_OK;
    endfunction

    function automatic int build_prefix(ref longint lines[MaxLines], input int cnt,
                                        ref logic [WlBits-1:0] pre[MaxLines]);
        longint m1, m2;
        pre[0] = '0;
        for (int i = 0; i + 2 < cnt; i++) begin
            m1 = (lines[i] + lines[i+1]) / 2;
            m2 = (lines[i+1] + lines[i+2]) / 2;
            pre[i+1] = pre[i] + WlBits'(m2 - m1);
        end
        return (cnt >= 2) ? cnt - 1 : 1;
    endfunction

    function automatic logic [WlBits-1:0] span(ref logic [WlBits-1:0] pre[MaxLines],
                                               input int a, input int b);
        return (a < b) ? pre[b] - pre[a] : pre[a] - pre[b];
    endfunction

    function automatic t_answer predict_answer(t_row r);
        t_answer ans;
        ans.wl = WlZero;
        ans.st = ST_OK;
        case (r.cmd)
            CMD_LOAD_X: begin
                built = 0;
                ans.st = insert_coord(lines_x, cnt_x, longint'(r.coord));
            end
            CMD_LOAD_Y: begin
                built = 0;
                ans.st = insert_coord(lines_y, cnt_y, longint'(r.coord));
            end
            CMD_BUILD: begin
                ent_x = build_prefix(lines_x, cnt_x, pre_x);
                ent_y = build_prefix(lines_y, cnt_y, pre_y);
                built = 1;
            end
            default: begin
                if (!built) ans.st = ST_NOT_BUILT;
                else if (r.pc >= ent_x || r.qc >= ent_x || r.pr >= ent_y || r.qr >= ent_y)
                    ans.st = ST_RANGE;
                else ans.wl = span(pre_x, r.pc, r.qc) + span(pre_y, r.pr, r.qr);
            end
        endcase
        return ans;
    endfunction

    task automatic issue_cmd(t_row r);
        t_answer ans;
        repeat ($urandom_range(0, 5)) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_command <= r.cmd;
        i_coord   <= r.coord;
        i_p_col   <= r.pc;
        i_p_row   <= r.pr;
        i_q_col   <= r.qc;
        i_q_row   <= r.qr;
        do @(posedge i_clk); while (busy);
        ans = predict_answer(r);
        if (r.typed) begin
            ans.wl = r.wl;
            ans.st = r.st;
        end
        answers_pending = {answers_pending, ans};
    endtask

    always @(posedge i_clk) begin
        t_answer e;
        if (o_valid) begin
            if (answers_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result wl=%0d st=%0d",
                                               o_wire_length, o_status);
            end else begin
                e = answers_pending.pop_front();
                if (o_wire_length !== e.wl || o_status !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp wl=%0d st=%0d got wl=%0d st=%0d",
                                 e.wl, e.st, o_wire_length, o_status);
                end
            end
        end
    end

    function automatic t_row mk(t_cmd c, logic signed [31:0] co, int pc, int pr, int qc,
                                int qr, bit typed, logic [WlBits-1:0] wl, t_status st);
        t_row r;
        r.cmd = c; r.coord = co;
        r.pc = 10'(pc); r.pr = 10'(pr); r.qc = 10'(qc); r.qr = 10'(qr);
        r.typed = typed; r.wl = wl; r.st = st;
        return r;
    endfunction

    function automatic t_row rand_row();
        t_row r;
        int   k;
        r = mk(CMD_QUERY, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 1023), 0, WlZero, ST_OK);
        k = $urandom_range(0, 99);
        if (k < 25) begin
            r.cmd = (k < 13) ? CMD_LOAD_X : CMD_LOAD_Y;
            if ($urandom_range(0, 4) == 0) begin
                if (r.cmd == CMD_LOAD_X && cnt_x > 0)
                    r.coord = 32'(lines_x[$urandom_range(0, cnt_x - 1)]);
                else if (r.cmd == CMD_LOAD_Y && cnt_y > 0)
                    r.coord = 32'(lines_y[$urandom_range(0, cnt_y - 1)]);
            end else if ($urandom_range(0, 1)) begin
                r.coord = $signed($urandom_range(0, 2000)) - 1000;
            end
        end else if (k < 30 || (!built && k < 60)) begin
            r.cmd = CMD_BUILD;
        end else if (built && $urandom_range(0, 9) != 0) begin
            r.pc = 10'($urandom_range(0, ent_x - 1));
            r.qc = 10'($urandom_range(0, ent_x - 1));
            r.pr = 10'($urandom_range(0, ent_y - 1));
            r.qr = 10'($urandom_range(0, ent_y - 1));
        end
        return r;
    endfunction

    t_row stim_table[$];

    initial begin
        stim_table = '{
            mk(CMD_QUERY, 0, 0, 0, 0, 0, 1, WlZero, ST_NOT_BUILT),
            mk(CMD_BUILD, 0, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_QUERY, 0, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_QUERY, 0, 1, 0, 0, 0, 1, WlZero, ST_RANGE),
            mk(CMD_QUERY, 0, 0, 0, 0, 1023, 1, WlZero, ST_RANGE),
            mk(CMD_LOAD_X, 32'sh80000000, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_LOAD_X, 32'sh7fffffff, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_LOAD_X, 0, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_LOAD_X, 0, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_LOAD_X, -3, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_LOAD_Y, -5, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_LOAD_Y, 7, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_LOAD_Y, 3, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_LOAD_Y, -4, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_QUERY, 0, 0, 0, 0, 0, 1, WlZero, ST_NOT_BUILT),
            mk(CMD_BUILD, 0, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_QUERY, 0, 0, 0, 2, 2, 0, WlZero, ST_OK),
            mk(CMD_QUERY, 0, 2, 2, 0, 0, 0, WlZero, ST_OK),
            mk(CMD_QUERY, 0, 1, 2, 2, 1, 0, WlZero, ST_OK),
            mk(CMD_QUERY, 0, 3, 0, 0, 0, 1, WlZero, ST_RANGE),
            mk(CMD_QUERY, 0, 0, 0, 0, 3, 1, WlZero, ST_RANGE),
            mk(CMD_QUERY, 0, 1023, 1023, 1023, 1023, 1, WlZero, ST_RANGE),
            mk(CMD_LOAD_Y, 3, 0, 0, 0, 0, 1, WlZero, ST_OK),
            mk(CMD_QUERY, 0, 0, 0, 0, 0, 1, WlZero, ST_NOT_BUILT)
        };
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (stim_table[i]) issue_cmd(stim_table[i]);
        @(negedge i_clk);
        start <= 1'b0;
        wait (answers_pending.size() == 0);
        repeat (200) issue_cmd(rand_row());
        // fill the x list to capacity
        while (cnt_x < MaxLines) issue_cmd(mk(CMD_LOAD_X, $urandom, 0, 0, 0, 0, 0, WlZero, ST_OK));
        issue_cmd(mk(CMD_LOAD_X, 32'(lines_x[5]), 0, 0, 0, 0, 1, WlZero, ST_OK));
        issue_cmd(mk(CMD_LOAD_X, lines_x[0] - 64'sd1 > -64'sd2147483648 ?
                     32'(lines_x[0] - 1) : 32'(lines_x[1] + 1) + 32'sd0,
                     0, 0, 0, 0, 0, WlZero, ST_OK));
        issue_cmd(mk(CMD_BUILD, 0, 0, 0, 0, 0, 1, WlZero, ST_OK));
        issue_cmd(mk(CMD_QUERY, 0, 0, 0, 1022, 0, 0, WlZero, ST_OK));
        issue_cmd(mk(CMD_QUERY, 0, 1022, 0, 511, 0, 0, WlZero, ST_OK));
        issue_cmd(mk(CMD_QUERY, 0, 1023, 0, 0, 0, 1, WlZero, ST_RANGE));
        repeat (20) issue_cmd(rand_row());
        @(negedge i_clk);
        start <= 1'b0;
        wait (answers_pending.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && answers_pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
